>>> rtl/lcm_pkg.sv
// shared types, constants and codes for the lamport clock mutex node
package lcm_pkg;

    localparam int MAX_NODES   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int CLOCK_BITS  = 32;

    localparam int RANK_W  = 4;
    localparam int CNT_W   = 5;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int AGREE_W = 5;

    localparam logic [CNT_W-1:0]   MAX_NODES_C = CNT_W'(MAX_NODES);
    localparam logic [FILL_W-1:0]  QDEPTH_C    = FILL_W'(QUEUE_DEPTH);
    localparam logic [AGREE_W-1:0] AGREE_MAX   = '1;

    // opcodes of an input transaction
    localparam logic [1:0] OP_LOCAL_REQ = 2'd0;
    localparam logic [1:0] OP_RECV_REQ  = 2'd1;
    localparam logic [1:0] OP_RECV_ACK  = 2'd2;
    localparam logic [1:0] OP_RELEASE   = 2'd3;

    // kinds of an output transaction
    localparam logic [1:0] K_SEND_REQ = 2'd0;
    localparam logic [1:0] K_SEND_ACK = 2'd1;
    localparam logic [1:0] K_NONE     = 2'd2;
    localparam logic [1:0] K_DROPPED  = 2'd3;

    // register indexes on the config port
    localparam logic [1:0] REG_MY_RANK  = 2'd0;
    localparam logic [1:0] REG_NODE_CNT = 2'd1;
    localparam logic [1:0] REG_ARB_CNT  = 2'd2;

    typedef struct packed {
        logic [RANK_W-1:0] my_rank;
        logic [CNT_W-1:0]  peer_cnt;   // node count clamped to MAX_NODES
        logic [CNT_W-1:0]  need;       // agreements required for entry
    } t_cfg;

    typedef struct packed {
        logic [1:0]            op;
        logic [RANK_W-1:0]     sender;
        logic [CLOCK_BITS-1:0] mclk;
        logic [CLOCK_BITS-1:0] mstart;
    } t_item;

    typedef struct packed {
        logic [1:0]            kind;
        logic [RANK_W-1:0]     dest;
        logic [CLOCK_BITS-1:0] clk;
        logic [CLOCK_BITS-1:0] start;
        logic                  grant;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic [CLOCK_BITS-1:0] start;
        logic [RANK_W-1:0]     rank;
    } t_entry;

endpackage

>>> rtl/lamport_clock_mutex_node.sv
// top level of the lamport clock mutual exclusion node
// each result is loaded into the registered output from a sequencer state after acceptance; a local
//   request steps over its own rank without a result; one transaction at a time, paced by the
//   sequencer and stalled while the output register is full and not taken
// reset: synchronous active low; clears clock, request state, fifo pointers and config
//   registers (rank 0, node count 2, arbiter count 4); the deferral ram is not cleared
module lamport_clock_mutex_node import lcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // sender_rank[3:0], msg_clock[35:4], msg_start_clock[67:36]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // dest_rank[3:0], out_clock[35:4], out_start_clock[67:36],
                                        // granted[68]
    output logic [1:0]  m_axis_tuser,   // msg_kind[1:0]
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg              w_cfg;
    t_item             w_item;
    t_result           w_res;
    logic              w_ram_we;
    logic [QPTR_W-1:0] w_ram_waddr;
    t_entry            w_ram_wdata;
    logic              w_ram_re;
    logic [QPTR_W-1:0] w_ram_raddr;
    t_entry            w_ram_rdata;

    // unpack the input transaction
    assign w_item.op     = s_axis_tuser;
    assign w_item.sender = s_axis_tdata[3:0];
    assign w_item.mclk   = s_axis_tdata[35:4];
    assign w_item.mstart = s_axis_tdata[67:36];

    // pack the result transaction, zero fill to whole bytes
    assign m_axis_tdata = {3'b000, w_res.grant, w_res.start, w_res.clk, w_res.dest};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

    lcm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // deferred requests, circular buffer addressed by head and fill
    lcm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_defer_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    lcm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (w_item),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (w_res),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

endmodule

>>> rtl/lcm_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
module lcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lcm_apb_regs.sv
// apb configuration registers and derived node-set values
module lcm_apb_regs import lcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [RANK_W-1:0] r_my_rank;
    logic [CNT_W-1:0]  r_node_cnt;
    logic [CNT_W-1:0]  r_arb_cnt;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_rank  <= '0;
            r_node_cnt <= CNT_W'(2);
            r_arb_cnt  <= CNT_W'(4);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MY_RANK:  r_my_rank  <= pwdata[RANK_W-1:0];
                REG_NODE_CNT: r_node_cnt <= pwdata[CNT_W-1:0];
                REG_ARB_CNT:  r_arb_cnt  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MY_RANK:  prdata = {{(32-RANK_W){1'b0}}, r_my_rank};
            REG_NODE_CNT: prdata = {{(32-CNT_W){1'b0}}, r_node_cnt};
            REG_ARB_CNT:  prdata = {{(32-CNT_W){1'b0}}, r_arb_cnt};
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.my_rank  = r_my_rank;
        o_cfg.peer_cnt = (r_node_cnt > MAX_NODES_C) ? MAX_NODES_C : r_node_cnt;
        o_cfg.need     = (r_arb_cnt >= r_node_cnt) ? '0 : (r_node_cnt - r_arb_cnt);
    end

endmodule

>>> rtl/lcm_engine.sv
// protocol sequencer: clock, request state, fifo pointers and result register
module lcm_engine import lcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  t_item                 i_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output logic                  o_ram_we,
    output logic [QPTR_W-1:0]     o_ram_waddr,
    output t_entry                o_ram_wdata,
    output logic                  o_ram_re,
    output logic [QPTR_W-1:0]     o_ram_raddr,
    input  t_entry                i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_MSG,
        S_POP,
        S_ONE
    } t_state;

    t_state                r_state, n_state;
    t_item                 r_item, n_item;
    logic [CLOCK_BITS-1:0] r_clock, n_clock;
    logic                  r_wanting, n_wanting;
    logic [CLOCK_BITS-1:0] r_start, n_start;
    logic [AGREE_W-1:0]    r_agree, n_agree;
    logic [QPTR_W-1:0]     r_head, n_head;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_last_idx, n_last_idx;
    logic                  r_first, n_first;
    logic                  r_grant, n_grant;
    logic                  r_ov, n_ov;
    t_result               r_res, n_res;

    logic                  w_load;
    logic                  w_accept;
    logic                  w_rank_in;
    logic [CNT_W-1:0]      w_nemit;
    logic [CLOCK_BITS-1:0] w_max;
    logic [CLOCK_BITS-1:0] w_tick;
    logic                  w_ack;
    logic [CLOCK_BITS-1:0] w_req_clk;

    assign w_load       = !r_ov || i_res_ready;
    assign o_item_ready = (r_state == S_IDLE);
    assign w_accept     = i_item_valid && o_item_ready;
    assign o_res_valid  = r_ov;
    assign o_res        = r_res;

    // peers addressed by a local request: node set minus this node
    assign w_rank_in = {1'b0, i_cfg.my_rank} < i_cfg.peer_cnt;
    assign w_nemit   = i_cfg.peer_cnt - CNT_W'(w_rank_in);

    // clock merge for received messages
    assign w_max  = (r_item.mclk > r_clock) ? r_item.mclk : r_clock;
    assign w_tick = r_clock + CLOCK_BITS'(1);
    assign w_req_clk = r_first ? w_tick : r_start;
    assign w_ack  = !r_wanting || (r_item.mstart < r_start) ||
                    ((r_item.mstart == r_start) && (r_item.sender < i_cfg.my_rank));

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_clock    = r_clock;
        n_wanting  = r_wanting;
        n_start    = r_start;
        n_agree    = r_agree;
        n_head     = r_head;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_first    = r_first;
        n_grant    = r_grant;
        n_ov       = r_ov && !i_res_ready;
        n_res      = r_res;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_head + r_fill[QPTR_W-1:0];
        o_ram_wdata = '{start: r_item.mstart, rank: r_item.sender};
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item = i_item;
                    case (i_item.op)
                        OP_LOCAL_REQ: begin
                            n_wanting  = 1'b1;
                            n_agree    = '0;
                            n_grant    = (i_cfg.need == '0);
                            n_idx      = '0;
                            n_first    = 1'b1;
                            n_last_idx = ({1'b0, i_cfg.my_rank} == i_cfg.peer_cnt - CNT_W'(1))
                                       ? i_cfg.peer_cnt - CNT_W'(2)
                                       : i_cfg.peer_cnt - CNT_W'(1);
                            n_state    = (w_nemit == '0) ? S_ONE : S_REQ;
                        end
                        OP_RELEASE: begin
                            n_wanting = 1'b0;
                            n_agree   = '0;
                            n_grant   = 1'b0;
                            // prefetch the head entry so popping runs one per cycle while the output register is taken
                            o_ram_re  = (r_fill != '0);
                            n_state   = (r_fill == '0) ? S_ONE : S_POP;
                        end
                        default: begin
                            n_state = S_MSG;
                        end
                    endcase
                end
            end

            S_ONE: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_res   = '{kind: K_NONE, dest: '0, clk: '0, start: '0,
                                grant: r_grant, last: 1'b1};
                    n_state = S_IDLE;
                end
            end

            S_REQ: begin
                if (r_idx == {1'b0, i_cfg.my_rank}) begin
                    n_idx = r_idx + CNT_W'(1);
                end else if (w_load) begin
                    n_clock = w_tick;
                    n_start = w_req_clk;
                    n_first = 1'b0;
                    n_ov    = 1'b1;
                    n_res   = '{kind: K_SEND_REQ, dest: r_idx[RANK_W-1:0], clk: w_tick,
                                start: w_req_clk, grant: r_grant,
                                last: (r_idx == r_last_idx)};
                    n_idx   = r_idx + CNT_W'(1);
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_MSG: begin
                if (w_load) begin
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                    n_clock = w_max + CLOCK_BITS'(1);
                    n_res   = '{kind: K_NONE, dest: '0, clk: '0, start: '0,
                                grant: r_wanting && (r_agree >= i_cfg.need), last: 1'b1};
                    if (r_item.op == OP_RECV_REQ) begin
                        if (w_ack) begin
                            n_clock      = w_max + CLOCK_BITS'(2);
                            n_res.kind   = K_SEND_ACK;
                            n_res.dest   = r_item.sender;
                            n_res.clk    = w_max + CLOCK_BITS'(2);
                            n_res.start  = r_item.mstart;
                        end else if (r_fill < QDEPTH_C) begin
                            o_ram_we = 1'b1;
                            n_fill   = r_fill + FILL_W'(1);
                        end else begin
                            n_res.kind = K_DROPPED;
                        end
                    end else begin
                        // acknowledgement: counted only against the current start clock
                        if ((r_item.mstart == r_start) && (r_agree != AGREE_MAX)) begin
                            n_agree = r_agree + AGREE_W'(1);
                        end
                        n_res.grant = r_wanting && (n_agree >= i_cfg.need);
                    end
                end
            end

            S_POP: begin
                if (w_load) begin
                    n_clock = w_tick;
                    n_ov    = 1'b1;
                    n_res   = '{kind: K_SEND_ACK, dest: i_ram_rdata.rank, clk: w_tick,
                                start: i_ram_rdata.start, grant: r_grant,
                                last: (r_fill == FILL_W'(1))};
                    n_head  = r_head + QPTR_W'(1);
                    n_fill  = r_fill - FILL_W'(1);
                    o_ram_raddr = r_head + QPTR_W'(1);
                    if (r_fill == FILL_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ram_re = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clock   <= '0;
            r_wanting <= 1'b0;
            r_start   <= '0;
            r_agree   <= '0;
            r_head    <= '0;
            r_fill    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clock   <= n_clock;
            r_wanting <= n_wanting;
            r_start   <= n_start;
            r_agree   <= n_agree;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_ov      <= n_ov;
        end
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_first    <= n_first;
        r_grant    <= n_grant;
        r_res      <= n_res;
    end

endmodule
